/* src/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSO_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sso check failed");

// Next-cycle implication, disabled during reset.
`define SSO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sso check failed");

`endif

/* src/sso_pkg.sv */
// Shared types, constants and the sine table generator of the oscillator.
// No dependencies.
package sso_pkg;

  localparam int PHASE_BITS = 32;
  localparam int SLICE_BITS = 8;
  localparam int CELL_COUNT = PHASE_BITS / SLICE_BITS;

  localparam logic [15:0] FULL_SCALE   = 16'd32767;
  localparam logic [14:0] AMP_RESET    = 15'd32767;
  localparam logic [14:0] SQUARE_RESET = 15'd8000;
  localparam logic [63:0] PI2_Q30      = 64'd1686629713;

  // Configuration register indexes
  localparam logic [1:0] REG_PHASE_STEP     = 2'd0;
  localparam logic [1:0] REG_WAVE_MODE      = 2'd1;
  localparam logic [1:0] REG_SINE_AMPLITUDE = 2'd2;
  localparam logic [1:0] REG_SQUARE_LEVEL   = 2'd3;

  localparam logic MODE_SINE   = 1'b0;
  localparam logic MODE_SQUARE = 1'b1;

  typedef struct packed {
    logic advance;
    logic restart;
  } cell_ctrl_t;

  // Quarter-wave entry k in Q1.15: Taylor series in Q30, evaluated at elaboration.
  function automatic logic [15:0] sine_entry(int unsigned k, int unsigned table_bits);
    logic [63:0] x;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] r;
    x    = 64'(k) << (30 - table_bits);
    th   = (x * PI2_Q30) >> 30;
    th2  = (th * th) >> 30;
    term = th;
    pos  = th;
    neg  = 64'd0;
    term = ((term * th2) >> 30) / 6;
    neg  = neg + term;
    term = ((term * th2) >> 30) / 20;
    pos  = pos + term;
    term = ((term * th2) >> 30) / 42;
    neg  = neg + term;
    term = ((term * th2) >> 30) / 72;
    pos  = pos + term;
    term = ((term * th2) >> 30) / 110;
    neg  = neg + term;
    s = (pos >= neg) ? (pos - neg) : 64'd0;
    r = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
    if (r > 64'(FULL_SCALE)) begin
      r = 64'(FULL_SCALE);
    end
    return r[15:0];
  endfunction

endpackage

/* src/sso_phase_cell.sv */
// One slice of the phase accumulator: holds SLICE_BITS of phase, ripples carry on.
// Depends on sso_pkg.
module sso_phase_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  sso_pkg::cell_ctrl_t               ctrl,
  input  logic [sso_pkg::SLICE_BITS-1:0]    step_slice,
  input  logic                              carry_in,
  output logic [sso_pkg::SLICE_BITS-1:0]    cur_slice,
  output logic                              carry_out
);

  logic [sso_pkg::SLICE_BITS-1:0] phase_slice;
  logic [sso_pkg::SLICE_BITS:0]   sum;

  // Restart clears the slice before it is used and advanced
  assign cur_slice = ctrl.restart ? '0 : phase_slice;
  assign sum = {1'b0, cur_slice} + {1'b0, step_slice}
             + {{sso_pkg::SLICE_BITS{1'b0}}, carry_in};
  assign carry_out = sum[sso_pkg::SLICE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_slice <= '0;
    end else if (ctrl.advance) begin
      phase_slice <= sum[sso_pkg::SLICE_BITS-1:0];
    end
  end

endmodule

/* src/sso_sine_rom.sv */
// Quarter-wave sine ROM with registered read, contents built at elaboration.
// Depends on sso_pkg.
module sso_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [TABLE_BITS-1:0] rd_addr,
  output logic [15:0]           rd_data
);

  localparam int TABLE_SIZE = 1 << TABLE_BITS;

  typedef logic [15:0] rom_t [TABLE_SIZE];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      r[k] = sso_pkg::sine_entry(k, TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ROM[rd_addr];
    end
  end

endmodule

/* src/sine_square_oscillator.sv */
// Sine / square numerically controlled oscillator. Every accepted tick word
// yields one signed 16-bit sample word; a new tick can be taken every cycle
// unless tick_stall holds it off, and each sample passes the registered read of
// the sine ROM and then the output register. The 32-bit phase lives in a row of
// byte-wide accumulator cells that pass their carry along the row combinationally;
// restart_phase zeroes the phase before it is used for that sample. Sine mode
// folds a quarter-wave table of 2^TABLE_BITS entries and scales by
// sine_amplitude, truncating toward zero; square mode gives +square_level
// while 0 < phase < 2^31 and -square_level otherwise. Write configuration
// only while no samples are in flight. No fill pass follows reset.
// Depends on sso_pkg, sso_phase_cell and sso_sine_rom.
module sine_square_oscillator #(
  parameter int TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  // tick channel
  input  logic               tick_valid,
  output logic               tick_stall,
  input  logic               restart_phase,
  // sample channel
  output logic               sample_valid,
  input  logic               sample_stall,
  output logic signed [15:0] sample,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int PB = sso_pkg::PHASE_BITS;
  localparam int SB = sso_pkg::SLICE_BITS;
  localparam int NC = sso_pkg::CELL_COUNT;

  // Configuration registers
  logic [31:0] phase_step;
  logic        wave_mode;
  logic [14:0] sine_amplitude;
  logic [14:0] square_level;

  // Handshake
  logic accept;
  logic s1_load;
  logic out_load;
  logic s1_valid;

  // Phase row
  sso_pkg::cell_ctrl_t cell_ctrl;
  logic [PB-1:0]       cur_phase;
  logic [NC:0]         carry;

  // Lookup
  logic [1:0]            quad;
  logic [TABLE_BITS-1:0] idx;
  logic [TABLE_BITS-1:0] rom_addr;
  logic [15:0]           rom_data;
  logic                  square_neg;

  // Stage 1 payload
  logic s1_full;
  logic s1_neg;

  // Output math
  logic [15:0] table_mag;
  logic [30:0] prod;
  logic [15:0] mag;
  logic [15:0] val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step     <= '0;
      wave_mode      <= sso_pkg::MODE_SINE;
      sine_amplitude <= sso_pkg::AMP_RESET;
      square_level   <= sso_pkg::SQUARE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sso_pkg::REG_PHASE_STEP:     phase_step     <= cfg_data;
        sso_pkg::REG_WAVE_MODE:      wave_mode      <= cfg_data[0];
        sso_pkg::REG_SINE_AMPLITUDE: sine_amplitude <= cfg_data[14:0];
        sso_pkg::REG_SQUARE_LEVEL:   square_level   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Advance the output register when it is empty or being taken; advance
  // stage 1 when it is empty or can move into the output register.
  assign out_load   = !sample_valid || !sample_stall;
  assign s1_load    = !s1_valid || out_load;
  assign tick_stall = !s1_load;
  assign accept     = tick_valid && s1_load;

  // Phase accumulator: one cell per byte, carry ripples up the row.
  assign cell_ctrl.advance = accept;
  assign cell_ctrl.restart = restart_phase;
  assign carry[0] = 1'b0;

  for (genvar c = 0; c < NC; c++) begin : g_cell
    sso_phase_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .step_slice (phase_step[c*SB +: SB]),
      .carry_in   (carry[c]),
      .cur_slice  (cur_phase[c*SB +: SB]),
      .carry_out  (carry[c+1])
    );
  end
  // carry[NC] is the wrap-around carry: drop it

  // Fold the quarter wave: odd quadrants read the table mirrored, and the
  // mirror of index zero is full scale.
  assign quad       = cur_phase[PB-1 -: 2];
  assign idx        = cur_phase[PB-3 -: TABLE_BITS];
  assign rom_addr   = quad[0] ? ({TABLE_BITS{1'b0}} - idx) : idx;
  assign square_neg = cur_phase[PB-1] || (cur_phase == '0);

  sso_sine_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_full <= quad[0] && (idx == '0);
      s1_neg  <= (wave_mode == sso_pkg::MODE_SQUARE) ? square_neg : quad[1];
    end
  end

  // Scale, select the waveform and apply the sign
  assign table_mag = s1_full ? sso_pkg::FULL_SCALE : rom_data;
  assign prod      = 31'(sine_amplitude) * 31'(table_mag);
  assign mag       = (wave_mode == sso_pkg::MODE_SQUARE) ? {1'b0, square_level}
                                                         : prod[30:15];
  assign val       = s1_neg ? (16'd0 - mag) : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (out_load) begin
      sample_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      sample <= $signed(val);
    end
  end

endmodule

/* src/sso_checker.sv */
// Port-level checks of the oscillator, bound to the top level.
// Depends on assert_macros.svh and sine_square_oscillator.
`include "assert_macros.svh"

module sso_checker (
  input logic               clk,
  input logic               rst,
  input logic               tick_stall,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic signed [15:0] sample,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // An empty output never holds off ticks
  `SSO_ASSERT_NOW(a_no_stall_when_empty, clk, rst, !sample_valid, !tick_stall)

  // Magnitude never exceeds full scale, so the most negative code never shows
  `SSO_ASSERT_NOW(a_sample_range, clk, rst, sample_valid, sample != 16'sh8000)

  // A stalled sample word stays offered and unchanged
  `SSO_ASSERT_NEXT(a_sample_hold, clk, rst, sample_valid && sample_stall,
                   sample_valid && $stable(sample))

  // Configuration writes are never refused
  `SSO_ASSERT_NOW(a_cfg_open, clk, rst, cfg_valid, cfg_ready)

endmodule

bind sine_square_oscillator sso_checker u_sso_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for sine_square_oscillator: directed table, then random phases.
// Depends on sso_pkg and the oscillator RTL; sample words are checked against an
// in-bench oscillator predictor.
module tb;

  localparam int TBITS      = 10;
  localparam int TSIZE      = 1 << TBITS;
  localparam int WDOG_LIMIT = 2000;
  localparam int IDLE_PCT   = 23;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         index;
    logic [31:0]        data;
    logic               restart;
    logic               has_typed;
    logic signed [15:0] typed;
  } row_t;

  logic               clk;
  logic               rst;
  logic               tick_valid;
  logic               tick_stall;
  logic               restart_phase;
  logic               sample_valid;
  logic               sample_stall;
  logic signed [15:0] sample;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  sine_square_oscillator #(
    .TABLE_BITS(TBITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .restart_phase(restart_phase),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Oscillator predictor state: phase accumulator, register copies, quarter-wave table.
  logic [31:0] osc_phase;
  logic [31:0] osc_step;
  logic        osc_mode;
  logic [14:0] osc_amp;
  logic [14:0] osc_level;
  logic [15:0] quarter_wave [TSIZE];

  logic signed [15:0] expected_samples [$];
  int                 error_count;
  int                 quiet_cycles;
  bit                 idling_on;

  // Typed-in expectation travels with the tick word; latched by NBA so the
  // checker sees the value that belongs to the word it accepts.
  logic               exp_is_typed;
  logic signed [15:0] exp_typed_val;

  row_t directed_rows [$];

  // Quarter-wave entry k in Q1.15: odd Taylor series of sin in Q30, each term truncated.
  function automatic logic [15:0] quarter_value(int unsigned k);
    logic [63:0] x;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] r;
    int unsigned n;
    x    = 64'(k) << (30 - TBITS);
    th   = (x * sso_pkg::PI2_Q30) >> 30;
    th2  = (th * th) >> 30;
    term = th;
    pos  = th;
    neg  = 64'd0;
    for (n = 3; n <= 11; n += 2) begin
      term = ((term * th2) >> 30) / 64'((n - 1) * n);
      // alternate signs: x^3, x^7, x^11 subtract
      if ((((n - 1) / 2) % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    s = (pos >= neg) ? (pos - neg) : 64'd0;
    r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  // Sample word for a given phase under the current register copies.
  function automatic logic signed [15:0] osc_sample(logic [31:0] ph);
    logic [TBITS-1:0] idx;
    logic [15:0]      t;
    logic [31:0]      prod;
    logic [15:0]      mag;
    logic             neg;
    if (osc_mode == sso_pkg::MODE_SQUARE) begin
      // phase zero and one half both count as "not above zero"
      neg = (ph == 32'd0) || ph[31];
      mag = {1'b0, osc_level};
    end else begin
      idx = ph[29 -: TBITS];
      if (ph[30]) begin
        // falling quarter: mirror the index; index zero is the peak itself
        t = (idx == '0) ? sso_pkg::FULL_SCALE : quarter_wave[TSIZE - int'(idx)];
      end else begin
        t = quarter_wave[idx];
      end
      prod = 32'(osc_amp) * 32'(t);
      mag  = prod[30:15];
      neg  = ph[31];
    end
    return neg ? (16'd0 - mag) : mag;
  endfunction

  initial begin
    for (int k = 0; k < TSIZE; k++) begin
      quarter_wave[k] = quarter_value(k);
    end
  end

  // Sample channel stall: random pressure except in the quiet stretch.
  always @(posedge clk) begin
    if (rst) begin
      sample_stall <= 1'b0;
    end else begin
      sample_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Checker and predictor: drain sample words first, then apply register writes
  // and accepted tick words in the order the block sees them.
  always @(posedge clk) begin
    if (rst) begin
      osc_phase = 32'd0;
      osc_step  = 32'd0;
      osc_mode  = sso_pkg::MODE_SINE;
      osc_amp   = sso_pkg::AMP_RESET;
      osc_level = sso_pkg::SQUARE_RESET;
    end else begin
      if (sample_valid && !sample_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample word, expected none, actual %0d", $time, sample);
          error_count++;
        end else begin
          logic signed [15:0] want;
          want = expected_samples.pop_front();
          if (sample !== want) begin
            $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, sample);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sso_pkg::REG_PHASE_STEP:     osc_step  = cfg_data;
          sso_pkg::REG_WAVE_MODE:      osc_mode  = cfg_data[0];
          sso_pkg::REG_SINE_AMPLITUDE: osc_amp   = cfg_data[14:0];
          sso_pkg::REG_SQUARE_LEVEL:   osc_level = cfg_data[14:0];
          default: ;
        endcase
      end
      if (tick_valid && !tick_stall) begin
        // restart clears phase before this sample; advance phase after it
        if (restart_phase) begin
          osc_phase = 32'd0;
        end
        if (exp_is_typed) begin
          expected_samples.insert(expected_samples.size(), exp_typed_val);
        end else begin
          expected_samples.insert(expected_samples.size(), osc_sample(osc_phase));
        end
        osc_phase = osc_phase + osc_step;
      end
    end
  end

  // Watchdog: too long with no word moving on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (tick_valid && !tick_stall) || (sample_valid && !sample_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one tick word; optional random gaps before it. Returns at the accepting edge.
  task automatic send_tick(input logic restart, input logic has_typed,
                           input logic signed [15:0] typed);
    while (idling_on && ($urandom_range(99) < IDLE_PCT)) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid    <= 1'b1;
    restart_phase <= restart;
    exp_is_typed  <= has_typed;
    exp_typed_val <= typed;
    do @(posedge clk); while (tick_stall);
  endtask

  // Register write: drop tick valid, let the pipeline drain, then write.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    tick_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_tick(input logic restart, input logic has_typed,
                          input logic signed [15:0] typed);
    row_t r;
    r.kind      = ROW_TICK;
    r.index     = sso_pkg::REG_PHASE_STEP;
    r.data      = 32'd0;
    r.restart   = restart;
    r.has_typed = has_typed;
    r.typed     = typed;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task automatic add_cfg(input logic [1:0] index, input logic [31:0] data);
    row_t r;
    r.kind      = ROW_CFG;
    r.index     = index;
    r.data      = data;
    r.restart   = 1'b0;
    r.has_typed = 1'b0;
    r.typed     = '0;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Random register value: extremes often, otherwise anything in range.
  function automatic logic [31:0] pick_step();
    case ($urandom_range(6))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1;
      3: return 32'h8000_0000;
      4: return 32'($urandom_range(32'h0010_0000)); // walks the table entry by entry
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'h7FFF;
      // upper bits are masked off by the block
      2: return $urandom;
      default: return 32'($urandom_range(32767));
    endcase
  endfunction

  initial begin
    clk           = 1'b0;
    rst          <= 1'b1;
    tick_valid   <= 1'b0;
    restart_phase <= 1'b0;
    sample_stall <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= sso_pkg::REG_PHASE_STEP;
    cfg_data     <= 32'd0;
    exp_is_typed  <= 1'b0;
    exp_typed_val <= '0;
    idling_on    = 1'b1;

    // Directed table: reset state, quadrant boundaries, square edges, extremes.
    add_tick(1'b0, 1'b1, 16'sd0);               // reset: sine, phase zero
    add_cfg(sso_pkg::REG_PHASE_STEP, 32'h4000_0000);     // quarter-cycle steps
    add_tick(1'b1, 1'b1, 16'sd0);
    add_tick(1'b0, 1'b1, 16'sd32766);           // peak, full amplitude truncates
    add_tick(1'b0, 1'b1, 16'sd0);
    add_tick(1'b0, 1'b1, -16'sd32766);
    add_tick(1'b0, 1'b1, 16'sd0);               // phase wrapped to zero
    add_cfg(sso_pkg::REG_WAVE_MODE, {31'd0, sso_pkg::MODE_SQUARE});
    add_tick(1'b1, 1'b1, -16'sd8000);           // square at phase zero is low
    add_tick(1'b0, 1'b1, 16'sd8000);
    add_tick(1'b0, 1'b1, -16'sd8000);           // one half is low too
    add_tick(1'b0, 1'b1, -16'sd8000);
    add_cfg(sso_pkg::REG_SQUARE_LEVEL, 32'h7FFF);
    add_cfg(sso_pkg::REG_PHASE_STEP, 32'd1);
    add_tick(1'b1, 1'b1, -16'sd32767);
    add_tick(1'b0, 1'b1, 16'sd32767);           // smallest positive phase
    add_cfg(sso_pkg::REG_PHASE_STEP, 32'h7FFF_FFFF);
    add_tick(1'b1, 1'b1, -16'sd32767);
    add_tick(1'b0, 1'b1, 16'sd32767);           // just below one half
    add_tick(1'b0, 1'b1, -16'sd32767);
    add_cfg(sso_pkg::REG_SQUARE_LEVEL, 32'd0);
    add_tick(1'b1, 1'b1, 16'sd0);               // zero level gives zero both ways
    add_cfg(sso_pkg::REG_WAVE_MODE, {31'd0, sso_pkg::MODE_SINE});
    add_cfg(sso_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    add_cfg(sso_pkg::REG_SINE_AMPLITUDE, 32'd0);
    add_tick(1'b1, 1'b1, 16'sd0);
    add_tick(1'b0, 1'b1, 16'sd0);               // zero amplitude everywhere
    add_cfg(sso_pkg::REG_SINE_AMPLITUDE, 32'h7FFF);
    add_tick(1'b1, 1'b1, 16'sd0);
    add_tick(1'b0, 1'b0, '0);                   // mirrored index one, fourth quadrant
    add_tick(1'b0, 1'b0, '0);
    add_cfg(sso_pkg::REG_SINE_AMPLITUDE, 32'd1);
    add_cfg(sso_pkg::REG_PHASE_STEP, 32'h0C00_0000);
    add_tick(1'b1, 1'b0, '0);
    add_tick(1'b0, 1'b0, '0);
    add_tick(1'b0, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_tick(directed_rows[i].restart, directed_rows[i].has_typed,
                  directed_rows[i].typed);
      end
    end

    // Random phases: new register set, then a burst of ticks with rare restarts.
    // One phase runs with no gaps and no stalls at all.
    for (int p = 0; p < 11; p++) begin
      idling_on = (p != 4);
      write_reg(sso_pkg::REG_PHASE_STEP, pick_step());
      write_reg(sso_pkg::REG_WAVE_MODE, $urandom);
      write_reg(sso_pkg::REG_SINE_AMPLITUDE, pick_level());
      write_reg(sso_pkg::REG_SQUARE_LEVEL, pick_level());
      for (int n = 0; n < 105; n++) begin
        send_tick($urandom_range(99) < 5, 1'b0, '0);
      end
    end

    // Drain: hold valid low, wait for every sample word, then a short tail.
    tick_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
